// ----- hw/rtl/imdu_pkg.sv -----
// ----------------------------------------------------------------------------
// imdu_pkg
// Operation codes and the per-cell control record of the multiply/divide chain.
// ----------------------------------------------------------------------------
package imdu_pkg;

   localparam int OpW = 4;
   localparam int RegW = 5;
   localparam int PortW = 64;

   typedef enum logic [OpW-1:0] {
      OP_MUL    = 4'd0,
      OP_MULH   = 4'd1,
      OP_MULHSU = 4'd2,
      OP_MULHU  = 4'd3,
      OP_DIV    = 4'd4,
      OP_DIVU   = 4'd5,
      OP_REM    = 4'd6,
      OP_REMU   = 4'd7,
      OP_MULW   = 4'd8,
      OP_DIVW   = 4'd9,
      OP_DIVUW  = 4'd10,
      OP_REMW   = 4'd11,
      OP_REMUW  = 4'd12
   } op_type;

   // control that travels with an item down the chain
   typedef struct packed {
      logic            valid;
      logic            is_mul;
      logic            is_rem;
      logic            hi_sel;
      logic            word;
      logic            neg_q;
      logic            neg_r;
      logic            div_zero;
      logic            ovf;
      logic            bad_op;
      logic [RegW-1:0] dest;
   } ctrl_type;

endpackage

// ----- hw/rtl/integer_multiply_divide_unit.sv -----
// ----------------------------------------------------------------------------
// integer_multiply_divide_unit
// Integer multiply, divide and remainder with 32-bit word forms.
// ----------------------------------------------------------------------------
// Usage: an item (req_type, req_operand_a, req_operand_b, req_dest_reg) is
// taken on a clock edge where req_valid is high and req_stall is low. The
// result (rsp_result_value, rsp_result_reg) is offered with rsp_valid and
// held until a clock edge where rsp_stall is low.
// Operands are decoded into magnitudes combinationally in front of a chain
// of XLEN registered cells (one multiply or divide step per cell); the
// fix-up logic after the last cell feeds the output register.
// The whole chain advances together: one item per cycle is taken while
// the output is drained; a stalled output freezes the chain, and req_stall
// rises only when the output register is full and stalled.
// Reset clears all valid bits; payload stages are not cleared.
// ----------------------------------------------------------------------------
module integer_multiply_divide_unit
   import imdu_pkg::*;
#(
   parameter int XLEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [OpW-1:0]   req_type,
   input  logic [PortW-1:0] req_operand_a,
   input  logic [PortW-1:0] req_operand_b,
   input  logic [RegW-1:0]  req_dest_reg,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PortW-1:0] rsp_result_value,
   output logic [RegW-1:0]  rsp_result_reg
);

   localparam int W = XLEN;

   logic adv;
   ctrl_type       c_ch [W+1];
   logic [2*W-1:0] a_ch [W+1];
   logic [W-1:0]   o_ch [W+1];
   logic [W:0]     s_ch [W+1];

   ctrl_type       ctrl_in;
   logic [2*W-1:0] acc0;
   logic [W-1:0]   opd0;
   logic [W-1:0]   a, b, aw, bw, ma, mb;
   logic           an, bn, is_mul, signed_div, bz, ovf;
   op_type         op;

   ctrl_type       out_ctrl_ff;
   logic [W-1:0]   out_val_ff, val_in;

   // whole chain moves when the output slot is free or being taken
   assign adv       = !(out_ctrl_ff.valid && rsp_stall);
   assign req_stall = !adv;

   // decode and operand preparation
   always_comb begin
      op  = op_type'(req_type);
      a   = req_operand_a[W-1:0];
      b   = req_operand_b[W-1:0];
      ctrl_in = '0;
      ctrl_in.valid = req_valid;
      ctrl_in.dest  = req_dest_reg;
      ctrl_in.word  = req_type[3];
      is_mul = (req_type inside {OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_MULW});
      signed_div = (req_type inside {OP_DIV, OP_REM, OP_DIVW, OP_REMW});
      ctrl_in.is_mul = is_mul;
      ctrl_in.is_rem = (req_type inside {OP_REM, OP_REMU, OP_REMW, OP_REMUW});
      ctrl_in.hi_sel = (req_type inside {OP_MULH, OP_MULHSU, OP_MULHU});
      ctrl_in.bad_op = (req_type > OP_REMUW);
      // word forms use sign- or zero-extended low halves
      if (req_type[3]) begin
         if (signed_div) begin
            aw = W'({{32{req_operand_a[31]}}, req_operand_a[31:0]});
            bw = W'({{32{req_operand_b[31]}}, req_operand_b[31:0]});
         end else begin
            aw = W'({32'd0, req_operand_a[31:0]});
            bw = W'({32'd0, req_operand_b[31:0]});
         end
      end else begin
         aw = a;
         bw = b;
      end
      an = signed_div && aw[W-1];
      bn = signed_div && bw[W-1];
      // signed high products: magnitudes, sign fixed at the end
      if (req_type inside {OP_MULH, OP_MULHSU}) begin
         an = a[W-1];
         bn = (op == OP_MULH) && b[W-1];
      end
      ma = an ? (~aw + 1'b1) : aw;
      mb = bn ? (~bw + 1'b1) : bw;
      bz  = (bw == '0);
      ovf = signed_div && !bz && (aw == (({1'b1, {(W-1){1'b0}}} >> (req_type[3] ? W-32 : 0))
            ^ (req_type[3] ? ~({W{1'b1}} >> (W-32)) : '0))) && (bw == '1);
      ctrl_in.div_zero = bz;
      ctrl_in.ovf      = ovf;
      ctrl_in.neg_q    = is_mul ? (an ^ bn) : (an ^ bn);
      ctrl_in.neg_r    = an;
      acc0 = {{W{1'b0}}, mb};
      opd0 = ma;
      if (!is_mul) begin
         acc0 = {{W{1'b0}}, ma};
         opd0 = mb;
      end
   end

   assign c_ch[0] = ctrl_in;
   assign a_ch[0] = acc0;
   assign o_ch[0] = opd0;
   assign s_ch[0] = '0;

   // chain of step cells
   for (genvar i = 0; i < W; i++) begin : g_cell
      imdu_cell #(.W(W)) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .ctrl_i(c_ch[i]),
         .acc_i (a_ch[i]),
         .opd_i (o_ch[i]),
         .sub_i (s_ch[i]),
         .ctrl_o(c_ch[i+1]),
         .acc_o (a_ch[i+1]),
         .opd_o (o_ch[i+1]),
         .sub_o (s_ch[i+1])
      );
   end

   // result fix-up: sign, special cases, word extension
   always_comb begin
      ctrl_type     c;
      logic [2*W-1:0] p;
      logic [W-1:0] q, r, v;
      c = c_ch[W];
      p = c.neg_q ? (~a_ch[W] + 1'b1) : a_ch[W];
      q = c.neg_q ? (~a_ch[W][W-1:0] + 1'b1) : a_ch[W][W-1:0];
      r = c.neg_r ? (~s_ch[W][W-1:0] + 1'b1) : s_ch[W][W-1:0];
      if (c.is_mul) begin
         v = c.hi_sel ? p[2*W-1:W] : p[W-1:0];
      end else if (c.div_zero) begin
         v = c.is_rem ? (c.neg_r ? ~o_ch[W] + 1'b1 : '0) : '1;
      end else if (c.ovf) begin
         v = c.is_rem ? '0 : q;
      end else begin
         v = c.is_rem ? r : q;
      end
      if (c.div_zero && c.is_rem) begin
         v = c.neg_r ? (~s_ch[W][W-1:0] + 1'b1) : s_ch[W][W-1:0];
      end
      if (c.word && !(c.div_zero && !c.is_rem)) begin
         v = W'({{32{v[31]}}, v[31:0]});
      end
      if (c.bad_op) begin
         v = '0;
      end
      val_in = v;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ctrl_ff <= c_ch[W];
      end
      if (adv) begin
         out_val_ff <= val_in;
      end
   end

   assign rsp_valid        = out_ctrl_ff.valid;
   assign rsp_result_value = PortW'(out_val_ff);
   assign rsp_result_reg   = out_ctrl_ff.dest;

   // a stalled result holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("result changed under stall");
   // input stalls only when the output slot is blocked
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

endmodule

// ----- hw/rtl/imdu_cell.sv -----
// ----------------------------------------------------------------------------
// imdu_cell
// One step of the chain: a shift-add multiply step or a restoring divide
// step on the incoming item, registered and handed on each cycle while adv is high.
// ----------------------------------------------------------------------------
module imdu_cell
   import imdu_pkg::*;
#(
   parameter int W = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  ctrl_type       ctrl_i,
   input  logic [2*W-1:0] acc_i,
   input  logic [W-1:0]   opd_i,
   input  logic [W:0]     sub_i,
   output ctrl_type       ctrl_o,
   output logic [2*W-1:0] acc_o,
   output logic [W-1:0]   opd_o,
   output logic [W:0]     sub_o
);

   ctrl_type       ctrl_ff;
   logic [2*W-1:0] acc_ff, acc_in;
   logic [W-1:0]   opd_ff;
   logic [W:0]     sub_ff, sub_in;
   logic [W+1:0]   sum;
   logic [W:0]     rem_sh;
   logic [W+1:0]   diff;

   // multiply: acc = {hi,multiplier}, shift right adding multiplicand
   // divide: sub = partial remainder, acc low = dividend bits / quotient
   always_comb begin
      sum    = '0;
      rem_sh = '0;
      diff   = '0;
      acc_in = acc_i;
      sub_in = sub_i;
      if (ctrl_i.is_mul) begin
         sum = {2'b00, acc_i[2*W-1:W]} + (acc_i[0] ? {2'b00, opd_i} : '0);
         acc_in = {sum[W:0], acc_i[W-1:1]};
      end else begin
         rem_sh = {sub_i[W-1:0], acc_i[W-1]};
         diff   = {1'b0, rem_sh} - {2'b00, opd_i};
         if (!diff[W+1]) begin
            sub_in = diff[W:0];
            acc_in = {acc_i[2*W-1:W], acc_i[W-2:0], 1'b1};
         end else begin
            sub_in = rem_sh;
            acc_in = {acc_i[2*W-1:W], acc_i[W-2:0], 1'b0};
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctrl_ff <= ctrl_i;
      end
      if (adv) begin
         acc_ff <= acc_in;
         opd_ff <= opd_i;
         sub_ff <= sub_in;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign acc_o  = acc_ff;
   assign opd_o  = opd_ff;
   assign sub_o  = sub_ff;

endmodule
